// File: sv/chunked_aligned_bump_allocator_core_macros.svh
// assertion macros shared by the bump allocator checks
`ifndef CHUNKED_ALIGNED_BUMP_ALLOCATOR_CORE_MACROS_SVH
`define CHUNKED_ALIGNED_BUMP_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CBUMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbump check failed");

// next-cycle implication, sampled on clk, off during rst
`define CBUMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbump check failed");

`endif

// File: sv/cbump_pkg.sv
// package: field widths, status codes and parameter defaults of the bump allocator
`timescale 1ns / 1ps
package cbump_pkg;

  localparam int REQ_W    = 27;
  localparam int ALIGN_W  = 5;
  localparam int IDX_W    = 3;
  localparam int OFS_W    = 26;
  localparam int STATUS_W = 2;

  // largest exponent the align field can carry
  localparam int ALIGN_MAX = (1 << ALIGN_W) - 1;

  localparam int CHUNK_BYTES_LOG2_DEF = 26;
  localparam int MAX_CHUNKS_DEF       = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_SAME = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_BIG  = 2'd3
  } status_t;

endpackage

// File: sv/chunked_aligned_bump_allocator_core.sv
// top level: chunked aligned bump allocator, one placement per item
//
// Hands out regions from a row of up to MAX_CHUNKS chunks of 2**CHUNK_BYTES_LOG2
// bytes. Each request item gives a size and an alignment exponent; the block
// rounds the bytes used in the newest chunk up to that alignment and places the
// region there if it still ends inside the chunk, otherwise it opens the next
// chunk and places the region at offset 0. The very first item that is not too
// large opens chunk 0. A request larger than a chunk reports status 3, and a
// request that needs a new chunk when all are open reports status 2; both return
// chunk 0, offset 0 and leave the allocator state alone. Rate is one item per
// clock while req_stall is low: the align, add and compare chain runs in the
// cycle an item is accepted and writes both the allocator state and a result
// register, so the next item sees the updated state at once; rsp_valid rises in
// the cycle after accept. The result register frees a place for a new item
// whenever it is empty or its item is taken in the same cycle, so req_stall
// only rises while rsp_valid is held by rsp_stall.
`timescale 1ns / 1ps
module chunked_aligned_bump_allocator_core
  import cbump_pkg::*;
#(
  parameter int CHUNK_BYTES_LOG2 = CHUNK_BYTES_LOG2_DEF,
  parameter int MAX_CHUNKS       = MAX_CHUNKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [REQ_W-1:0]    request_bytes,
  input  logic [ALIGN_W-1:0]  align_log2,
  // result channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [IDX_W-1:0]    chunk_index,
  output logic [OFS_W-1:0]    byte_offset,
  output logic [STATUS_W-1:0] status
);

  // chunk counter holds 0..MAX_CHUNKS, used count holds 0..chunk size
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int USED_W = CHUNK_BYTES_LOG2 + 1;
  // room for used count plus the widest align mask, plus one carry
  localparam int SUM_W  = ((CHUNK_BYTES_LOG2 > ALIGN_MAX) ? CHUNK_BYTES_LOG2 : ALIGN_MAX) + 2;
  localparam logic [SUM_W-1:0] CHUNK_SIZE = SUM_W'(1) << CHUNK_BYTES_LOG2;
  localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(MAX_CHUNKS);

  // allocator state
  logic [CNT_W-1:0]  chunks_open;
  logic [CNT_W-1:0]  chunks_open_next;
  logic [USED_W-1:0] bytes_used;
  logic [USED_W-1:0] bytes_used_next;

  // result register inputs
  logic [IDX_W-1:0]  chunk_index_next;
  logic [OFS_W-1:0]  byte_offset_next;
  status_t           status_next;

  logic              accept;
  logic [SUM_W-1:0]  req_ext;
  logic [SUM_W-1:0]  align_mask;
  logic [SUM_W-1:0]  start_pos;
  logic [SUM_W-1:0]  end_pos;
  logic              too_big;
  logic              none_open;
  logic              fits;
  logic              all_open;
  logic [CNT_W-1:0]  idx_cnt;

  // result register is free when empty or drained this cycle
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // align the used count, then see where the region would end
  always_comb begin
    req_ext    = SUM_W'(request_bytes);
    align_mask = (SUM_W'(1) << align_log2) - SUM_W'(1);
    start_pos  = (SUM_W'(bytes_used) + align_mask) & ~align_mask;
    end_pos    = start_pos + req_ext;
    too_big    = req_ext > CHUNK_SIZE;
    none_open  = chunks_open == '0;
    fits       = end_pos <= CHUNK_SIZE;
    all_open   = chunks_open >= CNT_LIMIT;
  end

  // placement decision; oversize check wins, first non-oversize item always opens chunk 0
  always_comb begin
    chunks_open_next = chunks_open;
    bytes_used_next  = bytes_used;
    idx_cnt          = '0;
    byte_offset_next = '0;
    status_next      = ST_BIG;
    if (too_big) begin
      status_next = ST_BIG;
    end else if (!none_open && fits) begin
      // same chunk, at the aligned offset
      bytes_used_next  = USED_W'(end_pos);
      idx_cnt          = chunks_open - CNT_W'(1);
      byte_offset_next = OFS_W'(start_pos);
      status_next      = ST_SAME;
    end else if (!none_open && all_open) begin
      status_next = ST_FULL;
    end else begin
      // open the next chunk, region at offset 0
      chunks_open_next = chunks_open + CNT_W'(1);
      bytes_used_next  = USED_W'(request_bytes);
      idx_cnt          = chunks_open;
      status_next      = ST_NEW;
    end
    chunk_index_next = IDX_W'(idx_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_open <= '0;
      bytes_used  <= '0;
    end else if (accept) begin
      chunks_open <= chunks_open_next;
      bytes_used  <= bytes_used_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chunk_index <= chunk_index_next;
      byte_offset <= byte_offset_next;
      status      <= status_next;
    end
  end

endmodule

// File: sv/cbump_checker.sv
// checker on the ports of the bump allocator, bound to the top level
`timescale 1ns / 1ps
`include "chunked_aligned_bump_allocator_core_macros.svh"
module cbump_checker
  import cbump_pkg::*;
#(
  parameter int CHUNK_BYTES_LOG2 = CHUNK_BYTES_LOG2_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic [REQ_W-1:0]    request_bytes,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [IDX_W-1:0]    chunk_index,
  input logic [OFS_W-1:0]    byte_offset,
  input logic [STATUS_W-1:0] status
);

  localparam logic [63:0] CHUNK_SIZE = 64'd1 << CHUNK_BYTES_LOG2;

  logic req_take;
  logic oversize;

  assign req_take = req_valid && !req_stall;
  assign oversize = 64'(request_bytes) > CHUNK_SIZE;

  // a held result keeps its fields
  `CBUMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
    rsp_valid && $stable(chunk_index) && $stable(byte_offset) && $stable(status))

  // every accepted item shows its result on the next cycle
  `CBUMP_ASSERT_NEXT(a_one_cycle, req_take, rsp_valid)

  // oversize requests report too large
  `CBUMP_ASSERT_NEXT(a_oversize, req_take && oversize, status == ST_BIG)

  // errors and new chunks place nothing past offset 0
  `CBUMP_ASSERT_NOW(a_zero_fields,
    rsp_valid && (status == ST_BIG || status == ST_FULL || status == ST_NEW),
    byte_offset == '0 && (status == ST_NEW || chunk_index == '0))

endmodule

bind chunked_aligned_bump_allocator_core cbump_checker #(
  .CHUNK_BYTES_LOG2(CHUNK_BYTES_LOG2)
) u_cbump_checker (.*);
